// ===== design/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types, codes and sizes of the grid ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  // map geometry and fixed point format
  localparam int MAP_WIDTH      = 32;
  localparam int MAP_HEIGHT     = 16;
  localparam int SCREEN_COLUMNS = 1024;
  localparam int FRAC_BITS      = 12;
  localparam int CELL_COUNT     = MAP_WIDTH * MAP_HEIGHT;
  localparam int CELL_AW        = $clog2(CELL_COUNT);
  localparam int COL_W          = $clog2(MAP_WIDTH);
  localparam int ROW_W          = $clog2(MAP_HEIGHT);

  // field widths
  localparam int IDX_W    = 9;
  localparam int KIND_W   = 4;
  localparam int SCOL_W   = 10;
  localparam int DIR_W    = 14;
  localparam int POS_IN_W = 18;
  localparam int RSTEP_W  = 13;
  localparam int STEPS_W  = 16;
  localparam int DIST_W   = 28;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 18;
  localparam int CFG_IW   = 2;

  // internal position: one sign bit plus one step of headroom over the input range
  localparam int POS_W = POS_IN_W + 2;

  // register reset values
  localparam logic [POS_IN_W-1:0] START_X_RST   = POS_IN_W'(8192);
  localparam logic [POS_IN_W-1:0] START_Y_RST   = POS_IN_W'(8192);
  localparam logic [RSTEP_W-1:0]  RAY_STEP_RST  = RSTEP_W'(41);
  localparam logic [STEPS_W-1:0]  MAX_STEPS_RST = STEPS_W'(4096);

  // register indexes
  localparam logic [CFG_IW-1:0] REG_START_X   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_START_Y   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RAY_STEP  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_STEPS = 2'd3;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic              clr_we;
    logic              mem_we;
    logic              load;
    logic              step;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic oob;
    logic cell_hit;
    logic steps_done;
    logic zero_limit;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/grm_ctrl.sv =====
// ----------------------------------------------------------------------------
// grm_ctrl
// Sequencer of the ray marcher: map clearing, map writes and the march loop.
// ----------------------------------------------------------------------------
module grm_ctrl
  import grm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_STEP   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_LIMIT;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_WRITE) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (sts.zero_limit) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_LIMIT;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.oob) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OOB;
          state_nxt      = S_FINISH;
        end else if (sts.cell_hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_HIT;
          state_nxt      = S_FINISH;
        end else if (sts.steps_done) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_LIMIT;
          state_nxt      = S_FINISH;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/grm_datapath.sv =====
// ----------------------------------------------------------------------------
// grm_datapath
// Map memory, settings, ray position and distance, and the result register.
// ----------------------------------------------------------------------------
module grm_datapath
  import grm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [IDX_W-1:0]    in_cell_index,
  input  logic [KIND_W-1:0]   in_cell_value,
  input  logic [SCOL_W-1:0]   in_column,
  input  logic signed [DIR_W-1:0] in_step_x,
  input  logic signed [DIR_W-1:0] in_step_y,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SCOL_W-1:0]   out_ray_column,
  output logic [STAT_W-1:0]   out_status,
  output logic [KIND_W-1:0]   out_wall_kind,
  output logic [DIST_W-1:0]   out_distance,
  output logic [POS_IN_W-1:0] out_hit_x,
  output logic [POS_IN_W-1:0] out_hit_y
);

  // settings
  logic [POS_IN_W-1:0] start_x_r, start_y_r;
  logic [RSTEP_W-1:0]  ray_step_r;
  logic [STEPS_W-1:0]  max_steps_r;

  // map memory
  logic [KIND_W-1:0]  mem [CELL_COUNT];
  logic [KIND_W-1:0]  rdata_r;
  logic [CELL_AW-1:0] clr_cnt_r;
  logic [CELL_AW-1:0] waddr;
  logic [KIND_W-1:0]  wdata;
  logic               we;
  logic               idx_ok;

  // ray state
  logic signed [POS_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [DIR_W-1:0] dx_r, dy_r;
  logic [DIST_W-1:0]       dist_r, dist_nxt;
  logic [DIST_W:0]         dist_sum;
  logic [STEPS_W-1:0]      steps_r;
  logic [SCOL_W-1:0]       col_r;
  logic                    oob_r, oob_nxt;
  logic [COL_W-1:0]        cx;
  logic [ROW_W-1:0]        cy;
  logic [CELL_AW-1:0]      raddr;

  // pending result and output register
  logic [STAT_W-1:0]   res_status_r;
  logic [KIND_W-1:0]   res_kind_r;
  logic                out_valid_r;
  logic [SCOL_W-1:0]   out_col_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [POS_IN_W-1:0] out_x_r, out_y_r;
  logic [POS_IN_W-1:0] sat_x, sat_y;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= START_X_RST;
      start_y_r   <= START_Y_RST;
      ray_step_r  <= RAY_STEP_RST;
      max_steps_r <= MAX_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X:   start_x_r   <= cfg_wdata[POS_IN_W-1:0];
        REG_START_Y:   start_y_r   <= cfg_wdata[POS_IN_W-1:0];
        REG_RAY_STEP:  ray_step_r  <= cfg_wdata[RSTEP_W-1:0];
        REG_MAX_STEPS: max_steps_r <= cfg_wdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // write port: clearing sweep or map-write transaction
  assign idx_ok = (32'(in_cell_index) < 32'(CELL_COUNT));
  assign we     = cmd.clr_we || (cmd.mem_we && idx_ok);
  assign waddr  = cmd.clr_we ? clr_cnt_r : in_cell_index[CELL_AW-1:0];
  assign wdata  = cmd.clr_we ? '0 : in_cell_value;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // one march step: next position, distance and map check
  assign px_nxt   = px_r + POS_W'(dx_r);
  assign py_nxt   = py_r + POS_W'(dy_r);
  assign dist_sum = {1'b0, dist_r} + (DIST_W + 1)'(ray_step_r);
  assign dist_nxt = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
  assign oob_nxt  = px_nxt[POS_W-1] || py_nxt[POS_W-1]
                 || (32'(px_nxt[POS_W-2:FRAC_BITS]) >= 32'(MAP_WIDTH))
                 || (32'(py_nxt[POS_W-2:FRAC_BITS]) >= 32'(MAP_HEIGHT));
  assign cx       = px_nxt[FRAC_BITS+COL_W-1:FRAC_BITS];
  assign cy       = py_nxt[FRAC_BITS+ROW_W-1:FRAC_BITS];
  assign raddr    = CELL_AW'(32'(cy) * 32'(MAP_WIDTH) + 32'(cx));

  // registered map read
  always_ff @(posedge clk) begin
    if (cmd.step) rdata_r <= mem[raddr];
  end

  // ray registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= $signed({{(POS_W - POS_IN_W){1'b0}}, start_x_r});
      py_r    <= $signed({{(POS_W - POS_IN_W){1'b0}}, start_y_r});
      dx_r    <= in_step_x;
      dy_r    <= in_step_y;
      col_r   <= in_column;
      dist_r  <= '0;
      steps_r <= '0;
      oob_r   <= 1'b0;
    end else if (cmd.step) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      dist_r  <= dist_nxt;
      steps_r <= steps_r + 1'b1;
      oob_r   <= oob_nxt;
    end
  end

  // pending result code and kind
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_kind_r   <= (cmd.res_status == ST_HIT) ? rdata_r : '0;
    end
  end

  // position saturation for the report
  assign sat_x = px_r[POS_W-1] ? '0 :
                 (px_r[POS_W-2:POS_IN_W] != '0) ? '1 : px_r[POS_IN_W-1:0];
  assign sat_y = py_r[POS_W-1] ? '0 :
                 (py_r[POS_W-2:POS_IN_W] != '0) ? '1 : py_r[POS_IN_W-1:0];

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col_r    <= col_r;
      out_status_r <= res_status_r;
      out_kind_r   <= res_kind_r;
      out_dist_r   <= dist_r;
      out_x_r      <= sat_x;
      out_y_r      <= sat_y;
    end
  end

  // status to the controller
  assign sts.clr_last   = (clr_cnt_r == CELL_AW'(CELL_COUNT - 1));
  assign sts.oob        = oob_r;
  assign sts.cell_hit   = (rdata_r != '0);
  assign sts.steps_done = (steps_r == max_steps_r);
  assign sts.zero_limit = (max_steps_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_ray_column = out_col_r;
  assign out_status     = out_status_r;
  assign out_wall_kind  = out_kind_r;
  assign out_distance   = out_dist_r;
  assign out_hit_x      = out_x_r;
  assign out_hit_y      = out_y_r;

endmodule

// ===== design/grid_ray_march.sv =====
// ----------------------------------------------------------------------------
// grid_ray_march
// Fixed step ray marcher over a grid map of wall cells.
// ----------------------------------------------------------------------------
// map write: taken in the idle state without stalling the input; cast: each march
// step passes a step state (position update and registered map read together)
// and a check state, and a cast with a zero step limit goes straight to the
// finish state, which waits for a free output register; one item at a time
// results wait in an output register; input accepts until a finished cast finds it full
// after reset a clearing sweep zeroes all 512 map cells with the input stalled
module grid_ray_march
  import grm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [IDX_W-1:0]        in_cell_index,
  input  logic [KIND_W-1:0]       in_cell_value,
  input  logic [SCOL_W-1:0]       in_column,
  input  logic signed [DIR_W-1:0] in_step_x,
  input  logic signed [DIR_W-1:0] in_step_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SCOL_W-1:0]       out_ray_column,
  output logic [STAT_W-1:0]       out_status,
  output logic [KIND_W-1:0]       out_wall_kind,
  output logic [DIST_W-1:0]       out_distance,
  output logic [POS_IN_W-1:0]     out_hit_x,
  output logic [POS_IN_W-1:0]     out_hit_y
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  grm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // map, ray arithmetic and result register
  grm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_cell_index  (in_cell_index),
    .in_cell_value  (in_cell_value),
    .in_column      (in_column),
    .in_step_x      (in_step_x),
    .in_step_y      (in_step_y),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ray_column (out_ray_column),
    .out_status     (out_status),
    .out_wall_kind  (out_wall_kind),
    .out_distance   (out_distance),
    .out_hit_x      (out_hit_x),
    .out_hit_y      (out_hit_y)
  );

endmodule
